// File: sv/amgdfs_pkg.sv
`default_nettype none

package amgdfs_pkg;

    // Fixed field widths
    localparam int IDX_W    = 4;
    localparam int WEIGHT_W = 32;
    localparam int OP_W     = 3;
    localparam int CFG_W    = 5;

    // Reset value of node_count
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(16);

    // Operation codes; the spare code gets an empty result
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SETW   = 3'd2,
        OP_QUERY  = 3'd3,
        OP_FIRST  = 3'd4,
        OP_NEXT   = 3'd5,
        OP_DFS    = 3'd6
    } op_t;

    // What the output register is loaded with
    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_QUERY,
        RES_SCAN,
        RES_VISIT
    } res_kind_t;

    // Next value of the current row pointer
    typedef enum logic [2:0] {
        ROW_KEEP,
        ROW_SRC,
        ROW_ZERO,
        ROW_INC,
        ROW_PICK,
        ROW_STACK
    } row_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      capture;
        row_sel_t  row_sel;
        logic      col_all;
        logic      col_after_dst;
        logic      wr_weight;
        logic      rd_weight;
        logic      rd_row;
        logic      wr_row;
        logic      dfs_init;
        logic      dfs_push;
        logic      dfs_pop;
        logic      out_load;
        res_kind_t out_kind;
        logic      out_status;
        logic      out_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic bad_pair;
        logic bad_src;
        logic hit;
        logic last_row;
        logic depth_one;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: sv/amgdfs_ctrl.sv
`default_nettype none

module amgdfs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire amgdfs_pkg::sts_t  sts,
    output amgdfs_pkg::cmd_t       cmd,
    output logic                   in_ready
);
    import amgdfs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ROW_RD,
        ST_EDGE_WR,
        ST_SCAN_EV,
        ST_DFS_EV,
        ST_DFS_POP,
        ST_RESULT
    } state_t;

    state_t    state_reg,  state_next;
    res_kind_t kind_reg,   kind_next;
    logic      status_reg, status_next;
    logic      last_reg,   last_next;

    // Next state and command decode
    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        last_next   = last_reg;
        cmd         = '0;
        in_ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE: begin
                cmd.row_sel = ROW_SRC;
                kind_next   = RES_PLAIN;
                last_next   = 1'b1;
                status_next = 1'b0;
                unique case (sts.op)
                    OP_ADD: begin
                        if (sts.bad_pair) begin
                            status_next = 1'b1;
                            state_next  = ST_RESULT;
                        end else begin
                            cmd.wr_weight = 1'b1;
                            state_next    = ST_ROW_RD;
                        end
                    end
                    OP_REMOVE: begin
                        if (sts.bad_pair) begin
                            status_next = 1'b1;
                            state_next  = ST_RESULT;
                        end else begin
                            state_next = ST_ROW_RD;
                        end
                    end
                    OP_SETW: begin
                        if (sts.bad_pair) begin
                            status_next = 1'b1;
                        end else begin
                            cmd.wr_weight = 1'b1;
                        end
                        state_next = ST_RESULT;
                    end
                    OP_QUERY: begin
                        if (sts.bad_pair) begin
                            status_next = 1'b1;
                            state_next  = ST_RESULT;
                        end else begin
                            cmd.rd_weight = 1'b1;
                            state_next    = ST_ROW_RD;
                        end
                    end
                    OP_FIRST: begin
                        cmd.row_sel = ROW_ZERO;
                        cmd.col_all = 1'b1;
                        state_next  = ST_ROW_RD;
                    end
                    OP_NEXT: begin
                        if (sts.bad_pair) begin
                            status_next = 1'b1;
                            state_next  = ST_RESULT;
                        end else begin
                            cmd.col_after_dst = 1'b1;
                            state_next        = ST_ROW_RD;
                        end
                    end
                    OP_DFS: begin
                        if (sts.bad_src) begin
                            status_next = 1'b1;
                            state_next  = ST_RESULT;
                        end else begin
                            cmd.dfs_init = 1'b1;
                            state_next   = ST_ROW_RD;
                        end
                    end
                    default: begin
                        // spare code: empty result, no state change
                        state_next = ST_RESULT;
                    end
                endcase
            end

            ST_ROW_RD: begin
                cmd.rd_row = 1'b1;
                unique case (sts.op)
                    OP_ADD, OP_REMOVE: state_next = ST_EDGE_WR;
                    OP_QUERY: begin
                        kind_next  = RES_QUERY;
                        state_next = ST_RESULT;
                    end
                    OP_FIRST, OP_NEXT: state_next = ST_SCAN_EV;
                    OP_DFS:            state_next = ST_DFS_EV;
                    default:           state_next = ST_IDLE;
                endcase
            end

            ST_EDGE_WR: begin
                cmd.wr_row = 1'b1;
                state_next = ST_RESULT;
            end

            // One row of the row-major scan
            ST_SCAN_EV: begin
                if (sts.hit) begin
                    kind_next  = RES_SCAN;
                    state_next = ST_RESULT;
                end else if (sts.last_row) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.row_sel = ROW_INC;
                    cmd.col_all = 1'b1;
                    state_next  = ST_ROW_RD;
                end
            end

            // Walk step: descend to the lowest unvisited neighbor or backtrack
            ST_DFS_EV: begin
                if (sts.hit) begin
                    if (sts.out_free) begin
                        // previous node goes out, it is not the last one
                        cmd.out_load = 1'b1;
                        cmd.out_kind = RES_VISIT;
                        cmd.dfs_push = 1'b1;
                        cmd.row_sel  = ROW_PICK;
                        state_next   = ST_ROW_RD;
                    end
                end else if (sts.depth_one) begin
                    kind_next  = RES_VISIT;
                    state_next = ST_RESULT;
                end else begin
                    cmd.dfs_pop = 1'b1;
                    state_next  = ST_DFS_POP;
                end
            end

            ST_DFS_POP: begin
                cmd.row_sel = ROW_STACK;
                state_next  = ST_ROW_RD;
            end

            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = kind_reg;
                    cmd.out_status = status_reg;
                    cmd.out_last   = last_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            kind_reg   <= RES_PLAIN;
            status_reg <= 1'b0;
            last_reg   <= 1'b1;
        end else begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/amgdfs_dpath.sv
`default_nettype none

module amgdfs_dpath #(
    parameter int MAX_NODES = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire amgdfs_pkg::cmd_t                  cmd,
    output amgdfs_pkg::sts_t                       sts,
    input  wire logic [amgdfs_pkg::OP_W-1:0]       s_op,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]      s_src_node,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]      s_dst_node,
    input  wire logic [amgdfs_pkg::WEIGHT_W-1:0]   s_weight,
    input  wire logic                              cfg_we,
    input  wire logic [amgdfs_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic                                   m_status,
    output logic                                   m_edge_exists,
    output logic [amgdfs_pkg::WEIGHT_W-1:0]        m_edge_weight,
    output logic                                   m_found,
    output logic [amgdfs_pkg::IDX_W-1:0]           m_found_src,
    output logic [amgdfs_pkg::IDX_W-1:0]           m_found_dst,
    output logic [amgdfs_pkg::IDX_W-1:0]           m_visited_node,
    output logic                                   m_last
);
    import amgdfs_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DEP_W  = CNT_W;
    localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES);

    typedef logic [MAX_NODES-1:0] row_t;

    // lowest set bit of a row
    function automatic logic [NODE_W-1:0] first_set(input row_t v);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int j = MAX_NODES - 1; j >= 0; j--) begin
            if (v[j]) idx = NODE_W'(j);
        end
        return idx;
    endfunction

    // Captured transaction
    op_t                 op_reg;
    logic [IDX_W-1:0]    src_reg;
    logic [IDX_W-1:0]    dst_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic [CFG_W-1:0]    node_count_reg;

    // Adjacency rows, weights and walk stack
    row_t                row_mem    [MAX_NODES];
    logic [WEIGHT_W-1:0] weight_mem [MAX_NODES*MAX_NODES];
    logic [NODE_W-1:0]   stack_mem  [MAX_NODES];

    row_t                row_valid_reg;
    row_t                row_q_reg;
    logic                rv_q_reg;
    logic [WEIGHT_W-1:0] weight_q_reg;
    logic [NODE_W-1:0]   stack_q_reg;

    logic [NODE_W-1:0]   cur_row_reg, cur_row_next;
    row_t                colmask_reg;
    row_t                visited_reg;
    logic [DEP_W-1:0]    depth_reg;
    logic [NODE_W-1:0]   pending_reg;

    logic                m_valid_reg;
    logic                status_reg;
    logic                exists_reg;
    logic [WEIGHT_W-1:0] eweight_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    fsrc_reg;
    logic [IDX_W-1:0]    fdst_reg;
    logic [IDX_W-1:0]    visited_node_reg;
    logic                last_reg;

    logic [CMP_W-1:0]    n_eff;
    logic [NODE_W-1:0]   src_idx;
    logic [NODE_W-1:0]   dst_idx;
    logic [ADDR_W-1:0]   waddr;
    row_t                nmask;
    row_t                after_mask;
    row_t                row_data;
    row_t                row_new;
    row_t                cand;
    logic [NODE_W-1:0]   pick;
    logic                out_free;

    // Nodes in use, clamped to the matrix size
    always_comb begin
        if (CMP_W'(node_count_reg) > CMP_W'(MAX_NODES)) begin
            n_eff = CMP_W'(MAX_NODES);
        end else begin
            n_eff = CMP_W'(node_count_reg);
        end
    end

    assign src_idx = NODE_W'(src_reg);
    assign dst_idx = NODE_W'(dst_reg);
    assign waddr   = ADDR_W'(src_idx) * ADDR_W'(MAX_NODES) + ADDR_W'(dst_idx);

    // Column masks
    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            nmask[j]      = CMP_W'(j) < n_eff;
            after_mask[j] = CMP_W'(j) > CMP_W'(dst_reg);
        end
    end

    // Rows never written since the last clear read as empty
    assign row_data = rv_q_reg ? row_q_reg : '0;

    always_comb begin
        row_new          = row_data;
        row_new[dst_idx] = (op_reg == OP_ADD);
    end

    // Candidate columns: unvisited for a walk, past the start point for a scan
    assign cand     = row_data & nmask & ((op_reg == OP_DFS) ? ~visited_reg : colmask_reg);
    assign pick     = first_set(cand);
    assign out_free = !m_valid_reg || m_ready;

    assign sts.op        = op_reg;
    assign sts.bad_src   = CMP_W'(src_reg) >= n_eff;
    assign sts.bad_pair  = (CMP_W'(src_reg) >= n_eff) || (CMP_W'(dst_reg) >= n_eff);
    assign sts.hit       = |cand;
    assign sts.last_row  = (CMP_W'(cur_row_reg) + CMP_W'(1)) >= n_eff;
    assign sts.depth_one = depth_reg == DEP_W'(1);
    assign sts.out_free  = out_free;

    // Capture registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= op_t'(s_op);
            src_reg    <= s_src_node;
            dst_reg    <= s_dst_node;
            weight_reg <= s_weight;
        end
    end

    // Node count register and row clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
            row_valid_reg  <= '0;
        end else if (cfg_we) begin
            node_count_reg <= cfg_wdata;
            row_valid_reg  <= '0;
        end else if (cmd.wr_row) begin
            row_valid_reg[cur_row_reg] <= 1'b1;
        end
    end

    // Adjacency row memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_row) begin
            row_mem[cur_row_reg] <= row_new;
        end
        if (cmd.rd_row) begin
            row_q_reg <= row_mem[cur_row_reg];
            rv_q_reg  <= row_valid_reg[cur_row_reg];
        end
    end

    // Weight memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_weight) begin
            weight_mem[waddr] <= weight_reg;
        end
        if (cmd.rd_weight) begin
            weight_q_reg <= weight_mem[waddr];
        end
    end

    // Walk stack memory
    always_ff @(posedge aclk) begin
        if (cmd.dfs_init) begin
            stack_mem[0] <= src_idx;
        end else if (cmd.dfs_push) begin
            stack_mem[NODE_W'(depth_reg)] <= pick;
        end
        if (cmd.dfs_pop) begin
            stack_q_reg <= stack_mem[NODE_W'(depth_reg - DEP_W'(2))];
        end
    end

    // Row pointer
    always_comb begin
        unique case (cmd.row_sel)
            ROW_SRC:   cur_row_next = src_idx;
            ROW_ZERO:  cur_row_next = '0;
            ROW_INC:   cur_row_next = cur_row_reg + NODE_W'(1);
            ROW_PICK:  cur_row_next = pick;
            ROW_STACK: cur_row_next = stack_q_reg;
            default:   cur_row_next = cur_row_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_row_reg <= cur_row_next;
        if (cmd.col_all) begin
            colmask_reg <= '1;
        end else if (cmd.col_after_dst) begin
            colmask_reg <= after_mask;
        end
        if (cmd.dfs_init) begin
            pending_reg <= src_idx;
        end else if (cmd.dfs_push) begin
            pending_reg <= pick;
        end
    end

    // Walk bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            depth_reg   <= '0;
        end else if (cmd.dfs_init) begin
            visited_reg <= row_t'(1) << src_idx;
            depth_reg   <= DEP_W'(1);
        end else if (cmd.dfs_push) begin
            visited_reg <= visited_reg | (row_t'(1) << pick);
            depth_reg   <= depth_reg + DEP_W'(1);
        end else if (cmd.dfs_pop) begin
            depth_reg   <= depth_reg - DEP_W'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            status_reg       <= 1'b0;
            exists_reg       <= 1'b0;
            eweight_reg      <= '0;
            found_reg        <= 1'b0;
            fsrc_reg         <= '0;
            fdst_reg         <= '0;
            visited_node_reg <= '0;
            last_reg         <= 1'b1;
            unique case (cmd.out_kind)
                RES_PLAIN: begin
                    status_reg <= cmd.out_status;
                end
                RES_QUERY: begin
                    exists_reg  <= row_data[dst_idx];
                    eweight_reg <= weight_q_reg;
                end
                RES_SCAN: begin
                    found_reg <= 1'b1;
                    fsrc_reg  <= IDX_W'(cur_row_reg);
                    fdst_reg  <= IDX_W'(pick);
                end
                RES_VISIT: begin
                    visited_node_reg <= IDX_W'(pending_reg);
                    last_reg         <= cmd.out_last;
                end
                default: begin
                    status_reg <= cmd.out_status;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_edge_exists  = exists_reg;
    assign m_edge_weight  = eweight_reg;
    assign m_found        = found_reg;
    assign m_found_src    = fsrc_reg;
    assign m_found_dst    = fdst_reg;
    assign m_visited_node = visited_node_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

// File: sv/adjacency_matrix_graph_dfs_top.sv
`default_nettype none

// Directed graph store with a preorder depth-first walk. Each input
// transaction is one operation on a MAX_NODES x MAX_NODES adjacency matrix of
// edge-present bits and 32-bit weights: add, remove, set weight, query, first
// edge, next edge (row-major) or walk from s_src_node. Operations 0 to 5 and
// the spare code return one result; a walk returns one result per visited
// node with m_last on the final one. Node indices that an operation uses and
// that lie at or above node_count (clamped to MAX_NODES) return m_status = 1
// and leave the graph unchanged. Writing node_count removes every edge;
// weights are kept, and a weight read before it was ever written is
// undefined. One operation is in flight at a time, and the output register
// lets the next transaction in while a result waits. Add and remove do a
// read-modify-write of the adjacency row. Every step of a scan or walk is one
// read of the single-port adjacency row memory followed by an evaluation of
// that row; a backtrack also reads the walk stack first.
module adjacency_matrix_graph_dfs_top #(
    parameter int MAX_NODES = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [amgdfs_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [amgdfs_pkg::OP_W-1:0]       s_op,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]      s_src_node,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]      s_dst_node,
    input  wire logic [amgdfs_pkg::WEIGHT_W-1:0]   s_weight,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_status,
    output logic                                   m_edge_exists,
    output logic [amgdfs_pkg::WEIGHT_W-1:0]        m_edge_weight,
    output logic                                   m_found,
    output logic [amgdfs_pkg::IDX_W-1:0]           m_found_src,
    output logic [amgdfs_pkg::IDX_W-1:0]           m_found_dst,
    output logic [amgdfs_pkg::IDX_W-1:0]           m_visited_node,
    output logic                                   m_last
);
    import amgdfs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    amgdfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_ready)
    );

    amgdfs_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_op           (s_op),
        .s_src_node     (s_src_node),
        .s_dst_node     (s_dst_node),
        .s_weight       (s_weight),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_edge_exists  (m_edge_exists),
        .m_edge_weight  (m_edge_weight),
        .m_found        (m_found),
        .m_found_src    (m_found_src),
        .m_found_dst    (m_found_dst),
        .m_visited_node (m_visited_node),
        .m_last         (m_last)
    );

`ifndef NO_ASSERTIONS
    // one operation at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an operation is in flight");

    // only a walk produces non-final results, and those are never errors
    a_mid_walk_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !m_status && !m_found && !m_edge_exists)
        else $error("non-final result is not a walk node");

    // a found edge is a single, error-free result
    a_found_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_last && !m_status)
        else $error("found edge result malformed");
`endif

endmodule

`default_nettype wire

// File: verif/graph_walk_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the graph store. It keeps its own copy of the adjacency
// matrix and node count, works out the replies of each accepted operation and
// matches every accepted result against the oldest reply still due.
module graph_walk_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [amgdfs_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic [amgdfs_pkg::OP_W-1:0]     s_op,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]    s_src_node,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]    s_dst_node,
    input  wire logic [amgdfs_pkg::WEIGHT_W-1:0] s_weight,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic                            m_status,
    input  wire logic                            m_edge_exists,
    input  wire logic [amgdfs_pkg::WEIGHT_W-1:0] m_edge_weight,
    input  wire logic                            m_found,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]    m_found_src,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]    m_found_dst,
    input  wire logic [amgdfs_pkg::IDX_W-1:0]    m_visited_node,
    input  wire logic                            m_last,
    output int                                   mismatches,
    output int                                   replies_due,
    output int                                   ops_seen,
    output int                                   replies_seen,
    output int                                   walks_seen,
    output int                                   longest_walk
);
    import amgdfs_pkg::*;

    localparam int NODES = 16;

    typedef struct packed {
        logic                status;
        logic                exists;
        logic [WEIGHT_W-1:0] weight;
        logic                found;
        logic [IDX_W-1:0]    fsrc;
        logic [IDX_W-1:0]    fdst;
        logic [IDX_W-1:0]    visited;
        logic                last;
    } reply_t;

    // Mirror of the graph
    logic [CFG_W-1:0]    node_cnt;
    bit                  link [NODES][NODES];
    logic [WEIGHT_W-1:0] wt [NODES][NODES];

    // Replies predicted but not yet seen, oldest first
    reply_t              due_replies [$];

    function automatic string show(reply_t r);
        return $sformatf({"status=%0b exists=%0b weight=%h found=%0b src=%0d dst=%0d",
                          " visited=%0d last=%0b"},
                         r.status, r.exists, r.weight, r.found, r.fsrc, r.fdst,
                         r.visited, r.last);
    endfunction

    // Row-major search for the first edge strictly after (row, col)
    function automatic bit scan_edges(input int n, input int row, input int col,
                                      output int fs, output int fd);
        fs = 0;
        fd = 0;
        for (int i = row; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (!(i == row && j <= col) && link[i][j]) begin
                    fs = i;
                    fd = j;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic clear_links();
        for (int i = 0; i < NODES; i++)
            for (int j = 0; j < NODES; j++)
                link[i][j] = 1'b0;
    endtask

    // Update the mirror for one operation and queue its replies
    task automatic apply_graph_op(input logic [OP_W-1:0] op_bits,
                                  input logic [IDX_W-1:0] src,
                                  input logic [IDX_W-1:0] dst,
                                  input logic [WEIGHT_W-1:0] wval);
        reply_t r;
        reply_t walk [$];
        int     trail [$];
        bit     seen [NODES];
        int     n, fs, fd, here;
        bit     bad, stepped;

        n   = (node_cnt > NODES) ? NODES : int'(node_cnt);
        bad = (int'(src) >= n) || (int'(dst) >= n);
        r   = '0;
        r.last = 1'b1;
        unique case (op_t'(op_bits))
            OP_FIRST: begin
                // operands are ignored
                if (scan_edges(n, 0, -1, fs, fd)) begin
                    r.found = 1'b1;
                    r.fsrc  = IDX_W'(fs);
                    r.fdst  = IDX_W'(fd);
                end
                due_replies = {due_replies, r};
            end
            OP_DFS: begin
                if (int'(src) >= n) begin
                    r.status = 1'b1;
                    due_replies = {due_replies, r};
                end else begin
                    // preorder walk, lowest unvisited neighbor first
                    for (int i = 0; i < NODES; i++)
                        seen[i] = 1'b0;
                    seen[src] = 1'b1;
                    trail = {trail, int'(src)};
                    r = '0;
                    r.visited = src;
                    walk = {walk, r};
                    while (trail.size() > 0) begin
                        here    = trail[trail.size() - 1];
                        stepped = 1'b0;
                        for (int j = 0; j < n && !stepped; j++) begin
                            if (link[here][j] && !seen[j]) begin
                                seen[j] = 1'b1;
                                trail = {trail, j};
                                r = '0;
                                r.visited = IDX_W'(j);
                                walk = {walk, r};
                                stepped = 1'b1;
                            end
                        end
                        if (!stepped)
                            void'(trail.pop_back());
                    end
                    walk[walk.size() - 1].last = 1'b1;
                    walks_seen++;
                    if (walk.size() > longest_walk)
                        longest_walk = walk.size();
                    foreach (walk[k])
                        due_replies = {due_replies, walk[k]};
                end
            end
            OP_ADD, OP_REMOVE, OP_SETW, OP_QUERY, OP_NEXT: begin
                if (bad) begin
                    // graph untouched
                    r.status = 1'b1;
                end else begin
                    unique case (op_t'(op_bits))
                        OP_ADD: begin
                            link[src][dst] = 1'b1;
                            wt[src][dst]   = wval;
                        end
                        OP_REMOVE: link[src][dst] = 1'b0;
                        OP_SETW:   wt[src][dst]   = wval;
                        OP_QUERY: begin
                            r.exists = link[src][dst];
                            r.weight = wt[src][dst];
                        end
                        default: begin
                            if (scan_edges(n, int'(src), int'(dst), fs, fd)) begin
                                r.found = 1'b1;
                                r.fsrc  = IDX_W'(fs);
                                r.fdst  = IDX_W'(fd);
                            end
                        end
                    endcase
                end
                due_replies = {due_replies, r};
            end
            // spare code: empty reply
            default: due_replies = {due_replies, r};
        endcase
    endtask

    // Watch both channels and the count register at every rising edge
    always @(posedge aclk) begin : watch
        reply_t got, want;

        if (!aresetn) begin
            node_cnt = NODE_COUNT_RST;
            clear_links();
            for (int i = 0; i < NODES; i++)
                for (int j = 0; j < NODES; j++)
                    wt[i][j] = '0;
            due_replies.delete();
        end else begin
            // results first: a transaction taken at this edge cannot reply yet
            if (m_valid && m_ready) begin
                got.status  = m_status;
                got.exists  = m_edge_exists;
                got.weight  = m_edge_weight;
                got.found   = m_found;
                got.fsrc    = m_found_src;
                got.fdst    = m_found_dst;
                got.visited = m_visited_node;
                got.last    = m_last;
                replies_seen++;
                if (due_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no operation pending: %s", $time,
                                 show(got));
                end else begin
                    want = due_replies.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
            // a count write removes every edge, weights stay
            if (cfg_we) begin
                node_cnt = cfg_wdata;
                clear_links();
            end
            if (s_valid && s_ready) begin
                ops_seen++;
                apply_graph_op(s_op, s_src_node, s_dst_node, s_weight);
            end
        end
        replies_due = due_replies.size();
    end

endmodule

// File: verif/tb_adjacency_matrix_graph_dfs_top.sv
`timescale 1ns / 1ps

module tb_adjacency_matrix_graph_dfs_top;
    import amgdfs_pkg::*;

    localparam int              NODES    = 16;
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_op;
    logic [IDX_W-1:0]    s_src_node;
    logic [IDX_W-1:0]    s_dst_node;
    logic [WEIGHT_W-1:0] s_weight;
    logic                m_valid;
    logic                m_ready;
    logic                m_status;
    logic                m_edge_exists;
    logic [WEIGHT_W-1:0] m_edge_weight;
    logic                m_found;
    logic [IDX_W-1:0]    m_found_src;
    logic [IDX_W-1:0]    m_found_dst;
    logic [IDX_W-1:0]    m_visited_node;
    logic                m_last;

    int mismatches, replies_due, ops_seen, replies_seen, walks_seen, longest_walk;

    // Stimulus bookkeeping
    int live_nodes;
    int settings_run;
    int feed_calm;
    bit weight_set [NODES][NODES];

    always #1 aclk = ~aclk;

    adjacency_matrix_graph_dfs_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_src_node     (s_src_node),
        .s_dst_node     (s_dst_node),
        .s_weight       (s_weight),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_edge_exists  (m_edge_exists),
        .m_edge_weight  (m_edge_weight),
        .m_found        (m_found),
        .m_found_src    (m_found_src),
        .m_found_dst    (m_found_dst),
        .m_visited_node (m_visited_node),
        .m_last         (m_last)
    );

    graph_walk_checker walk_chk (.*);

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    // Any node index, in use or not
    function automatic logic [IDX_W-1:0] any_node();
        return IDX_W'($urandom_range(0, NODES - 1));
    endfunction

    // Node in use, with an occasional stray index
    function automatic logic [IDX_W-1:0] pick_node();
        if (live_nodes == 0 || $urandom_range(0, 9) == 0)
            return any_node();
        return IDX_W'($urandom_range(0, live_nodes - 1));
    endfunction

    // Send one operation; entered and left at a falling edge
    task automatic issue_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] src,
                            input logic [IDX_W-1:0] dst, input logic [WEIGHT_W-1:0] wval);
        int gap;
        bit in_range;

        in_range = (int'(src) < live_nodes) && (int'(dst) < live_nodes);
        // a weight is only read back once it has been written
        if (op == OP_QUERY && in_range && !weight_set[src][dst])
            op = OP_SETW;
        if ((op == OP_ADD || op == OP_SETW) && in_range)
            weight_set[src][dst] = 1'b1;

        if (feed_calm > 0) begin
            gap = 0;
            feed_calm--;
        end else begin
            gap = gap_len();
            if ($urandom_range(0, 99) < 3)
                feed_calm = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_src_node <= src;
        s_dst_node <= dst;
        s_weight   <= wval;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic random_ops(input int count);
        int               roll;
        logic [IDX_W-1:0] src, dst;

        repeat (count) begin
            roll = $urandom_range(0, 99);
            src  = pick_node();
            dst  = pick_node();
            if (roll < 8)
                issue_op(OP_W'($urandom_range(0, 7)), any_node(), any_node(), $urandom);
            else if (roll < 35)
                issue_op(OP_ADD, src, dst, pick_weight());
            else if (roll < 45)
                issue_op(OP_REMOVE, src, dst, $urandom);
            else if (roll < 52)
                issue_op(OP_SETW, src, dst, pick_weight());
            else if (roll < 65) begin
                // look for an entry whose weight is known
                for (int t = 0; t < 8 && !weight_set[src][dst]; t++) begin
                    src = pick_node();
                    dst = pick_node();
                end
                issue_op(OP_QUERY, src, dst, $urandom);
            end else if (roll < 70)
                issue_op(OP_FIRST, any_node(), any_node(), $urandom);
            else if (roll < 82)
                issue_op(OP_NEXT, src, dst, $urandom);
            else if (roll < 97)
                issue_op(OP_DFS, src, any_node(), $urandom);
            else
                issue_op(OP_SPARE, any_node(), any_node(), $urandom);
        end
    endtask

    // Chain every node in shuffled order, then walk from the head of the chain
    task automatic link_all_nodes();
        int order [NODES];
        int pick, held;

        if (live_nodes < 2) return;
        for (int i = 0; i < live_nodes; i++)
            order[i] = i;
        for (int i = live_nodes - 1; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            held        = order[i];
            order[i]    = order[pick];
            order[pick] = held;
        end
        for (int i = 0; i + 1 < live_nodes; i++)
            issue_op(OP_ADD, IDX_W'(order[i]), IDX_W'(order[i + 1]), pick_weight());
        issue_op(OP_DFS, IDX_W'(order[0]), any_node(), $urandom);
    endtask

    // Count write only once the block has gone quiet
    task automatic set_node_count(input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (replies_due != 0 || !s_ready) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        live_nodes = (value > NODES) ? NODES : int'(value);
        settings_run++;
    endtask

    // Result side: random stalls with calm stretches
    initial begin : drain
        int stall_left;
        int calm_left;

        m_ready    = 1'b0;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) < 2)
                    calm_left = $urandom_range(40, 160);
                else if ($urandom_range(0, 99) < 30)
                    stall_left = gap_len();
            end
        end
    end

    // Main sequence
    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_op         = '0;
        s_src_node   = '0;
        s_dst_node   = '0;
        s_weight     = '0;
        live_nodes   = NODES;
        settings_run = 1;
        feed_calm    = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // edge traffic at the reset count: extremes, scans, a small walk
        issue_op(OP_ADD, 4'd0, 4'd15, 32'hFFFF_FFFF);
        issue_op(OP_ADD, 4'd15, 4'd0, 32'h0000_0000);
        issue_op(OP_QUERY, 4'd0, 4'd15, $urandom);
        issue_op(OP_SETW, 4'd3, 4'd4, 32'hA5A5_A5A5);     // weight on absent edge
        issue_op(OP_QUERY, 4'd3, 4'd4, $urandom);
        issue_op(OP_FIRST, 4'd15, 4'd15, $urandom);
        issue_op(OP_NEXT, 4'd0, 4'd15, $urandom);
        issue_op(OP_NEXT, 4'd15, 4'd0, $urandom);         // runs off the end
        issue_op(OP_ADD, 4'd0, 4'd1, $urandom);
        issue_op(OP_ADD, 4'd1, 4'd2, $urandom);
        issue_op(OP_ADD, 4'd2, 4'd0, $urandom);
        issue_op(OP_ADD, 4'd1, 4'd3, $urandom);
        issue_op(OP_DFS, 4'd0, 4'd9, $urandom);
        issue_op(OP_REMOVE, 4'd0, 4'd15, $urandom);
        issue_op(OP_QUERY, 4'd0, 4'd15, $urandom);
        issue_op(OP_DFS, 4'd5, 4'd0, $urandom);           // isolated start
        issue_op(OP_SPARE, 4'd15, 4'd15, 32'hFFFF_FFFF);

        // five nodes: edges gone, weights kept, stray indices rejected
        set_node_count(5'd5);
        issue_op(OP_QUERY, 4'd0, 4'd1, $urandom);
        issue_op(OP_ADD, 4'd5, 4'd0, $urandom);
        issue_op(OP_QUERY, 4'd2, 4'd6, $urandom);
        issue_op(OP_NEXT, 4'd0, 4'd7, $urandom);
        issue_op(OP_DFS, 4'd9, 4'd0, $urandom);
        issue_op(OP_FIRST, 4'd0, 4'd0, $urandom);
        issue_op(OP_ADD, 4'd4, 4'd4, 32'h0000_0001);      // self loop
        issue_op(OP_DFS, 4'd4, 4'd4, $urandom);
        random_ops(12);

        set_node_count(5'd1);
        random_ops(8);
        set_node_count(5'd0);
        random_ops(6);
        set_node_count(5'd31);
        random_ops(20);
        link_all_nodes();
        random_ops(6);
        set_node_count(CFG_W'($urandom_range(2, 15)));
        random_ops(20);
        link_all_nodes();
        set_node_count(5'd16);
        link_all_nodes();
        random_ops(25);
        link_all_nodes();

        // let the last replies come out, then watch for strays
        s_valid <= 1'b0;
        while (replies_due != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);

        $display("Run: %0d operations under %0d node counts, %0d results checked",
                 ops_seen, settings_run, replies_seen);
        $display("Run: %0d depth-first walks, longest %0d nodes, %0d mismatches",
                 walks_seen, longest_walk, mismatches);
        if (mismatches == 0 && replies_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still due", replies_due);
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
sv/amgdfs_pkg.sv
sv/amgdfs_ctrl.sv
sv/amgdfs_dpath.sv
sv/adjacency_matrix_graph_dfs_top.sv
verif/graph_walk_checker.sv
verif/tb_adjacency_matrix_graph_dfs_top.sv
